// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the substring hash engine.
// Depends on nothing; users supply clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is asserted.
`define CHK_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Clocked invariant, disabled while reset is asserted.
`define CHK_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ===== sv/shlcp_pkg.sv =====
// Package for the substring hash / LCP engine: moduli, reset bases, opcodes,
// status codes, sequencer states and modular helper functions. No dependencies.
`timescale 1ns / 1ps
package shlcp_pkg;

	localparam int HASH_W = 30;
	localparam int FIELD_W = 13;
	localparam int MAX_LEN_DEF = 4096;

	localparam logic [31:0] MOD_ONE = 32'd1000000007;
	localparam logic [31:0] MOD_TWO = 32'd1000000009;
	localparam logic [HASH_W-1:0] BASE_ONE_RST = 30'd1007;
	localparam logic [HASH_W-1:0] BASE_TWO_RST = 30'd1009;

	localparam logic CFG_BASE_ONE = 1'b0;
	localparam logic CFG_BASE_TWO = 1'b1;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_HASH   = 2'd1,
		OP_MATCH  = 2'd2,
		OP_LCP    = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_APP_RD,
		S_APP_MPRE,
		S_APP_WPRE,
		S_APP_MPW,
		S_APP_WPW,
		S_H_RD,
		S_H_MUL,
		S_H_WAIT,
		S_LCP_STEP,
		S_DONE
	} state_t;

	// (a - b) mod m for a, b < m
	function automatic logic [HASH_W-1:0] mod_sub(input logic [HASH_W-1:0] a,
		input logic [HASH_W-1:0] b, input logic [31:0] m);
		logic [31:0] s;
		s = {2'b00, a} + m - {2'b00, b};
		if (s >= m) s = s - m;
		return s[HASH_W-1:0];
	endfunction

	// (a + c) mod m for a < m, c a byte
	function automatic logic [HASH_W-1:0] mod_add_byte(input logic [HASH_W-1:0] a,
		input logic [7:0] c, input logic [31:0] m);
		logic [31:0] s;
		s = {2'b00, a} + {24'd0, c};
		if (s >= m) s = s - m;
		return s[HASH_W-1:0];
	endfunction

endpackage

// ===== sv/shlcp_modmul.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on shlcp_pkg for the operand width.
`timescale 1ns / 1ps
module shlcp_modmul #(
	parameter logic [31:0] MOD = shlcp_pkg::MOD_ONE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [shlcp_pkg::HASH_W-1:0]  a,
	input  logic [shlcp_pkg::HASH_W-1:0]  b,
	output logic                          done,
	output logic [shlcp_pkg::HASH_W-1:0]  res
);
	localparam int W = shlcp_pkg::HASH_W;
	localparam int CNT_W = $clog2(W);
	localparam logic [31:0] MOD2 = MOD << 1;

	logic [W-1:0] a_q, b_q, acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic run_q, done_q;
	logic [31:0] t, t_red;

	// acc < MOD and a < MOD, so t < 3*MOD
	always_comb begin
		t = {1'b0, acc_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : 32'd0);
		if (t >= MOD2) t_red = t - MOD2;
		else if (t >= MOD) t_red = t - MOD;
		else t_red = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= t_red[W-1:0];
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res = acc_q;

endmodule

// ===== sv/substring_hash_lcp_engine_core.sv =====
// Top level of the substring hash / LCP engine: sequencer, tables, result register.
// Depends on shlcp_pkg, shlcp_modmul and assert_macros.svh.
//
//  channel | signals                              | direction | handshake
//  --------+--------------------------------------+-----------+-----------------
//  input   | op start_new char_byte left/right_a/b| in        | in_valid/in_ready
//  result  | hash_one hash_two match_flag         | out       | out_valid/out_ready
//          | prefix_length status                 |           |
//  config  | cfg_index cfg_wdata                  | in        | cfg_wr_en
//
// Products: every modular product runs through a 30-step bit-serial multiplier
// (one lane per modulus); a hash of one range needs one product, an append and a
// match two, and an LCP two for each probe that fits the string (none for one
// that does not), with at most ceil(log2(n+1)) probes.
// Reset: char_count clears and the bases return to 1007 / 1009; table entry zero
// is supplied by logic, the rest of the tables hold whatever is written.
// Stalls: a finished result waits in the output register; the next item is taken
// meanwhile, and its own result holds in S_DONE until the register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module substring_hash_lcp_engine_core #(
	parameter int MAX_LEN = shlcp_pkg::MAX_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [shlcp_pkg::HASH_W-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          op,
	input  logic                                start_new,
	input  logic [7:0]                          char_byte,
	input  logic [shlcp_pkg::FIELD_W-1:0]       left_a,
	input  logic [shlcp_pkg::FIELD_W-1:0]       right_a,
	input  logic [shlcp_pkg::FIELD_W-1:0]       left_b,
	input  logic [shlcp_pkg::FIELD_W-1:0]       right_b,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [shlcp_pkg::HASH_W-1:0]        hash_one,
	output logic [shlcp_pkg::HASH_W-1:0]        hash_two,
	output logic                                match_flag,
	output logic [shlcp_pkg::FIELD_W-1:0]       prefix_length,
	output logic [1:0]                          status
);
	localparam int HW = shlcp_pkg::HASH_W;
	localparam int FW = shlcp_pkg::FIELD_W;
	localparam int CW = $clog2(MAX_LEN + 1);          // char count / address width
	localparam int AW = CW;
	localparam int NW = ((CW > FW) ? CW : FW) + 1;    // index arithmetic width
	localparam int DEPTH = MAX_LEN + 1;

	shlcp_pkg::state_t state_q, state_d;

	// configuration
	logic [HW-1:0] base_one_q, base_two_q;

	// latched item
	shlcp_pkg::op_t op_q;
	logic sn_q;
	logic [7:0] ch_q;
	logic [NW-1:0] la_q, ra_q, lb_q, rb_q;

	// sequencing
	logic [CW-1:0] count_q;
	logic [NW-1:0] cur_l_q, cur_r_q, ok_q, ng_q, m_q;
	logic phase_q;
	logic [HW-1:0] ha1_q, ha2_q, np1_q, np2_q;

	// result being built and output register
	logic [HW-1:0] r_h1_q, r_h2_q, o_h1_q, o_h2_q;
	logic r_flag_q, o_flag_q;
	logic [FW-1:0] r_plen_q, o_plen_q;
	logic [1:0] r_st_q, o_st_q;
	logic out_valid_q;

	// tables: {modulus two, modulus one}
	logic [2*HW-1:0] pre_mem [DEPTH];
	logic [2*HW-1:0] pw_mem [DEPTH];
	logic [2*HW-1:0] pre_rd_q, pw_rd_q;
	logic pre_z_q, pw_z_q;
	logic pre_rd_en, pw_rd_en, mem_we;
	logic [AW-1:0] pre_addr, pw_addr, wr_addr;
	logic [HW-1:0] pre_v1, pre_v2, pw_v1, pw_v2;

	// shared multiplier lanes
	logic mul_start, done1, done2;
	logic [HW-1:0] mul_a1, mul_a2, mul_b1, mul_b2, mres1, mres2;

	// decode helpers
	logic in_xfer, done_fire;
	logic [NW-1:0] count_n, len, lcp_m;
	logic range_a_ok, range_b_ok, sfx_ok, full, lcp_more, lcp_fit;
	logic [HW-1:0] hv1, hv2;
	logic hash_eq;

	assign in_xfer = in_valid && in_ready;
	assign in_ready = (state_q == shlcp_pkg::S_IDLE);
	assign done_fire = (state_q == shlcp_pkg::S_DONE) && (!out_valid_q || out_ready);

	assign count_n = NW'(count_q);
	assign range_a_ok = (la_q <= ra_q) && (ra_q <= count_n);
	assign range_b_ok = (lb_q <= rb_q) && (rb_q <= count_n);
	assign sfx_ok = (la_q <= count_n) && (lb_q <= count_n);
	// store full after an optional clear
	assign full = !sn_q && (count_n == NW'(MAX_LEN));
	assign lcp_more = (ng_q - ok_q) > NW'(1);
	assign lcp_m = (ok_q + ng_q) >> 1;
	assign lcp_fit = (la_q + lcp_m <= count_n) && (lb_q + lcp_m <= count_n);
	assign len = cur_r_q - cur_l_q;

	// entry zero of every table is fixed by logic: prefix 0, power 1
	assign pre_v1 = pre_z_q ? '0 : pre_rd_q[HW-1:0];
	assign pre_v2 = pre_z_q ? '0 : pre_rd_q[2*HW-1:HW];
	assign pw_v1 = pw_z_q ? HW'(1) : pw_rd_q[HW-1:0];
	assign pw_v2 = pw_z_q ? HW'(1) : pw_rd_q[2*HW-1:HW];

	// pre_v holds prefix[r] by the time the product of prefix[l] * power[len] is done
	assign hv1 = shlcp_pkg::mod_sub(pre_v1, mres1, shlcp_pkg::MOD_ONE);
	assign hv2 = shlcp_pkg::mod_sub(pre_v2, mres2, shlcp_pkg::MOD_TWO);
	assign hash_eq = (hv1 == ha1_q) && (hv2 == ha2_q);

	shlcp_modmul #(.MOD(shlcp_pkg::MOD_ONE)) u_mul_one (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a1), .b(mul_b1), .done(done1), .res(mres1)
	);

	shlcp_modmul #(.MOD(shlcp_pkg::MOD_TWO)) u_mul_two (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a2), .b(mul_b2), .done(done2), .res(mres2)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			shlcp_pkg::S_IDLE: if (in_xfer) state_d = shlcp_pkg::S_DECODE;
			shlcp_pkg::S_DECODE: begin
				case (op_q)
					shlcp_pkg::OP_APPEND:
						state_d = full ? shlcp_pkg::S_DONE : shlcp_pkg::S_APP_RD;
					shlcp_pkg::OP_HASH:
						state_d = range_a_ok ? shlcp_pkg::S_H_RD : shlcp_pkg::S_DONE;
					shlcp_pkg::OP_MATCH:
						state_d = (range_a_ok && range_b_ok) ? shlcp_pkg::S_H_RD
							: shlcp_pkg::S_DONE;
					default:
						state_d = sfx_ok ? shlcp_pkg::S_LCP_STEP : shlcp_pkg::S_DONE;
				endcase
			end
			shlcp_pkg::S_APP_RD: state_d = shlcp_pkg::S_APP_MPRE;
			shlcp_pkg::S_APP_MPRE: state_d = shlcp_pkg::S_APP_WPRE;
			shlcp_pkg::S_APP_WPRE: if (done1) state_d = shlcp_pkg::S_APP_MPW;
			shlcp_pkg::S_APP_MPW: state_d = shlcp_pkg::S_APP_WPW;
			shlcp_pkg::S_APP_WPW: if (done1) state_d = shlcp_pkg::S_DONE;
			shlcp_pkg::S_H_RD: state_d = shlcp_pkg::S_H_MUL;
			shlcp_pkg::S_H_MUL: state_d = shlcp_pkg::S_H_WAIT;
			shlcp_pkg::S_H_WAIT: begin
				if (done1) begin
					if (op_q == shlcp_pkg::OP_HASH) state_d = shlcp_pkg::S_DONE;
					else if (!phase_q) state_d = shlcp_pkg::S_H_RD;
					else if (op_q == shlcp_pkg::OP_MATCH) state_d = shlcp_pkg::S_DONE;
					else state_d = shlcp_pkg::S_LCP_STEP;
				end
			end
			shlcp_pkg::S_LCP_STEP: begin
				if (!lcp_more) state_d = shlcp_pkg::S_DONE;
				else if (lcp_fit) state_d = shlcp_pkg::S_H_RD;
			end
			shlcp_pkg::S_DONE: if (done_fire) state_d = shlcp_pkg::S_IDLE;
			default: state_d = shlcp_pkg::S_IDLE;
		endcase
	end

	// table ports and multiplier controls
	always_comb begin
		pre_rd_en = 1'b0;
		pw_rd_en = 1'b0;
		pre_addr = count_q[AW-1:0];
		pw_addr = count_q[AW-1:0];
		mul_start = 1'b0;
		mul_a1 = pre_v1;
		mul_a2 = pre_v2;
		mul_b1 = base_one_q;
		mul_b2 = base_two_q;
		mem_we = 1'b0;
		wr_addr = AW'(count_n + NW'(1));
		case (state_q)
			shlcp_pkg::S_APP_RD: begin
				pre_rd_en = 1'b1;
				pw_rd_en = 1'b1;
			end
			shlcp_pkg::S_APP_MPRE: mul_start = 1'b1;
			shlcp_pkg::S_APP_MPW: begin
				mul_start = 1'b1;
				mul_a1 = pw_v1;
				mul_a2 = pw_v2;
			end
			shlcp_pkg::S_APP_WPW: mem_we = done1;
			shlcp_pkg::S_H_RD: begin
				pre_rd_en = 1'b1;
				pw_rd_en = 1'b1;
				pre_addr = cur_l_q[AW-1:0];
				pw_addr = len[AW-1:0];
			end
			shlcp_pkg::S_H_MUL: begin
				mul_start = 1'b1;
				mul_b1 = pw_v1;
				mul_b2 = pw_v2;
				pre_rd_en = 1'b1;
				pre_addr = cur_r_q[AW-1:0];
			end
			default: ;
		endcase
	end

	// tables
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pre_mem[wr_addr] <= {np2_q, np1_q};
			pw_mem[wr_addr] <= {mres2, mres1};
		end
		if (pre_rd_en) begin
			pre_rd_q <= pre_mem[pre_addr];
			pre_z_q <= (pre_addr == '0);
		end
		if (pw_rd_en) begin
			pw_rd_q <= pw_mem[pw_addr];
			pw_z_q <= (pw_addr == '0);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shlcp_pkg::S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
			base_one_q <= shlcp_pkg::BASE_ONE_RST;
			base_two_q <= shlcp_pkg::BASE_TWO_RST;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				if (cfg_index == shlcp_pkg::CFG_BASE_ONE) base_one_q <= cfg_wdata;
				else base_two_q <= cfg_wdata;
			end
			// clear the string on an append with start_new, then grow by one on each stored byte
			if (state_q == shlcp_pkg::S_DECODE && op_q == shlcp_pkg::OP_APPEND && sn_q)
				count_q <= '0;
			else if (mem_we)
				count_q <= count_q + 1'b1;
			if (done_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q <= shlcp_pkg::op_t'(op);
			sn_q <= start_new;
			ch_q <= char_byte;
			la_q <= NW'(left_a);
			ra_q <= NW'(right_a);
			lb_q <= NW'(left_b);
			rb_q <= NW'(right_b);
		end
		case (state_q)
			shlcp_pkg::S_DECODE: begin
				r_h1_q <= '0;
				r_h2_q <= '0;
				r_flag_q <= 1'b0;
				r_plen_q <= '0;
				r_st_q <= shlcp_pkg::ST_OK;
				cur_l_q <= la_q;
				cur_r_q <= ra_q;
				phase_q <= 1'b0;
				ok_q <= '0;
				ng_q <= count_n + NW'(1);
				case (op_q)
					shlcp_pkg::OP_APPEND: if (full) r_st_q <= shlcp_pkg::ST_FULL;
					shlcp_pkg::OP_HASH: if (!range_a_ok) r_st_q <= shlcp_pkg::ST_RANGE;
					shlcp_pkg::OP_MATCH:
						if (!(range_a_ok && range_b_ok)) r_st_q <= shlcp_pkg::ST_RANGE;
					default: if (!sfx_ok) r_st_q <= shlcp_pkg::ST_RANGE;
				endcase
			end
			shlcp_pkg::S_APP_WPRE: begin
				if (done1) begin
					np1_q <= shlcp_pkg::mod_add_byte(mres1, ch_q, shlcp_pkg::MOD_ONE);
					np2_q <= shlcp_pkg::mod_add_byte(mres2, ch_q, shlcp_pkg::MOD_TWO);
				end
			end
			shlcp_pkg::S_H_WAIT: begin
				if (done1) begin
					if (op_q == shlcp_pkg::OP_HASH) begin
						r_h1_q <= hv1;
						r_h2_q <= hv2;
					end else if (!phase_q) begin
						// hold the first range's hash, move on to the second range
						ha1_q <= hv1;
						ha2_q <= hv2;
						phase_q <= 1'b1;
						cur_l_q <= lb_q;
						cur_r_q <= (op_q == shlcp_pkg::OP_MATCH) ? rb_q : lb_q + m_q;
					end else if (op_q == shlcp_pkg::OP_MATCH) begin
						r_flag_q <= hash_eq;
					end else if (hash_eq) begin
						ok_q <= m_q;
					end else begin
						ng_q <= m_q;
					end
				end
			end
			shlcp_pkg::S_LCP_STEP: begin
				if (!lcp_more) begin
					r_plen_q <= ok_q[FW-1:0];
				end else if (lcp_fit) begin
					m_q <= lcp_m;
					cur_l_q <= la_q;
					cur_r_q <= la_q + lcp_m;
					phase_q <= 1'b0;
				end else begin
					// probe runs past the string: counts as no match
					ng_q <= lcp_m;
				end
			end
			default: ;
		endcase
		if (done_fire) begin
			o_h1_q <= r_h1_q;
			o_h2_q <= r_h2_q;
			o_flag_q <= r_flag_q;
			o_plen_q <= r_plen_q;
			o_st_q <= r_st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hash_one = o_h1_q;
	assign hash_two = o_h2_q;
	assign match_flag = o_flag_q;
	assign prefix_length = o_plen_q;
	assign status = o_st_q;

	`CHK_ALWAYS(a_count_bound, count_n <= NW'(MAX_LEN), "char count past capacity")
	`CHK_ALWAYS(a_lanes_lockstep, done1 == done2, "multiplier lanes out of step")
	`CHK_IMPLY(a_lcp_order, state_q == shlcp_pkg::S_LCP_STEP, ok_q < ng_q,
		"lcp search bounds crossed")
	`CHK_IMPLY(a_no_accept_busy, state_q != shlcp_pkg::S_IDLE, !in_ready,
		"input taken while sequencer busy")

endmodule
